### sv/xmcr_pkg.sv
// Shared constants for the XMODEM checksum receiver.
`timescale 1ns / 1ps
package xmcr_pkg;

  localparam int unsigned FRAME_BYTES = 132;
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned ERR_W       = 4;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned LANE_W      = $clog2(WORD_BYTES);

  // Frame layout
  localparam logic [ADDR_W-1:0] IDX_SEQ     = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] IDX_CMP     = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] IDX_PAY0    = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] IDX_PAYLAST = ADDR_W'(FRAME_BYTES - 2);
  localparam logic [ADDR_W-1:0] IDX_CKS     = ADDR_W'(FRAME_BYTES - 1);

  // Line symbols
  localparam logic [7:0] SYM_SOH = 8'd1;
  localparam logic [7:0] SYM_EOT = 8'd4;
  localparam logic [7:0] SYM_ACK = 8'd6;
  localparam logic [7:0] SYM_NAK = 8'd21;

  // Input item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;

  // Register indexes
  localparam logic [1:0] REG_SHORT_TO = 2'd0;
  localparam logic [1:0] REG_LONG_TO  = 2'd1;
  localparam logic [1:0] REG_ERR_LIM  = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0] SHORT_TO_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0] LONG_TO_RST  = TICK_W'(10000);
  localparam logic [ERR_W-1:0]  ERR_LIM_RST  = ERR_W'(10);
  localparam logic [ERR_W-1:0]  ERR_MAX      = '1;

endpackage

### sv/xmodem_checksum_receiver_top.sv
// XMODEM checksum receiver: frame buffer, protocol phases and check/delivery sequencer.
`timescale 1ns / 1ps
// A byte, tick or poll item updates the protocol state when taken; its replies (up to two)
//   leave in turn as the output register frees up.
// The byte that completes a frame starts a check sweep (one payload byte read and summed
//   per cycle), then a new frame is delivered as sixteen words of eight buffer reads each,
//   one read per cycle, each word waiting for the output register to free up.
// Throughput: one item at a time; in_ready_o stays low while the sequencer is busy.
// Reset: asynchronous, active low; clears phase, counters and registers to their defaults.
//   The frame buffer is not cleared; only bytes written for the current frame are read.
module xmodem_checksum_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        sink_ready_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reply_valid_o,
  output logic [7:0]  reply_byte_o,
  output logic        data_valid_o,
  output logic [63:0] data_word_o,
  output logic        data_last_o,
  output logic        transfer_done_o
);

  localparam int unsigned AW = xmcr_pkg::ADDR_W;
  localparam int unsigned TW = xmcr_pkg::TICK_W;
  localparam int unsigned EW = xmcr_pkg::ERR_W;
  localparam int unsigned LW = xmcr_pkg::LANE_W;

  // Protocol phase, as seen between items.
  typedef enum logic [2:0] {
    PH_START,
    PH_CONNECT,
    PH_COLLECT,
    PH_SINKWAIT,
    PH_RESPOND
  } phase_e;

  // Sequencer that emits results and runs the frame check and delivery.
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_NAK0,
    SQ_REPLY,
    SQ_SUM,
    SQ_SUMEND,
    SQ_VERDICT,
    SQ_FETCH,
    SQ_FETCHEND,
    SQ_WORD
  } seq_e;

  // configuration
  logic [TW-1:0] short_to_q, long_to_q;
  logic [EW-1:0] err_lim_q;

  // protocol state
  phase_e        phase_q;
  logic [TW-1:0] tl_q;
  logic [EW-1:0] ec_q;
  logic [AW-1:0] bc_q;
  logic [7:0]    last_seq_q;

  // frame fields captured on arrival
  logic [7:0]    seq_q;
  logic          cmp_ok_q;
  logic [7:0]    cks_q;

  // sequencer
  seq_e          sq_q;
  logic          pend_rep_q;
  logic [7:0]    rep_byte_q;
  logic          rep_done_q;
  logic [AW-1:0] addr_q;
  logic [LW-1:0] lane_q;
  logic          rd_pend_q;
  logic [7:0]    sum_q;
  logic [63:0]   word_q;

  // frame buffer
  logic [7:0]    frame_mem [xmcr_pkg::FRAME_BYTES];
  logic [7:0]    rd_data_q;

  // output register
  logic          out_valid_q;
  logic          reply_valid_q;
  logic [7:0]    reply_byte_q;
  logic          data_valid_q;
  logic [63:0]   data_word_q;
  logic          data_last_q;
  logic          done_q;

  // item decode and next protocol state
  logic          in_fire;
  logic          slot_free;
  logic          is_byte, is_tick;
  phase_e        ph_a, ph_n;
  logic [EW-1:0] ec_a, ec_n, ec_inc;
  logic [TW-1:0] tl_a, tl_n, tl_dec;
  logic [AW-1:0] bc_n;
  logic          expired;
  logic          nak0, rep_v, rep_done, chk, mem_we;
  logic [7:0]    rep_byte;
  logic          frame_ok, frame_new;

  assign in_ready_o = (sq_q == SQ_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign is_byte    = (kind_i == xmcr_pkg::KIND_BYTE);
  assign is_tick    = (kind_i == xmcr_pkg::KIND_TICK);

  // Error count saturates at its top value.
  assign ec_inc = (ec_a == xmcr_pkg::ERR_MAX) ? ec_a : ec_a + EW'(1);

  assign frame_ok  = cmp_ok_q && (sum_q == cks_q);
  assign frame_new = (seq_q != last_seq_q);

  // Work out what one item does to the protocol state and which replies it raises.
  always_comb begin
    ph_a = phase_q;
    ec_a = ec_q;
    tl_a = tl_q;
    // Restart once the error limit is reached while waiting on the sender.
    if (phase_q == PH_RESPOND && ec_q >= err_lim_q) begin
      ec_a = '0;
      ph_a = PH_START;
    end
    // Start: send NAK and fall through to connect wait.
    nak0 = (ph_a == PH_START);
    if (nak0) begin
      tl_a = short_to_q;
      ph_a = PH_CONNECT;
    end
    tl_dec  = (tl_a != '0) ? tl_a - TW'(1) : '0;
    expired = is_tick && (tl_dec == '0);

    ph_n     = ph_a;
    ec_n     = ec_a;
    tl_n     = tl_a;
    bc_n     = bc_q;
    rep_v    = 1'b0;
    rep_byte = xmcr_pkg::SYM_NAK;
    rep_done = 1'b0;
    chk      = 1'b0;
    mem_we   = 1'b0;

    unique case (ph_a)
      PH_CONNECT: begin
        if (is_byte && rx_byte_i == xmcr_pkg::SYM_SOH) begin
          bc_n = AW'(1);
          tl_n = short_to_q;
          ph_n = PH_COLLECT;
        end else if (is_tick) begin
          tl_n = tl_dec;
          if (expired) begin
            tl_n  = short_to_q;
            rep_v = 1'b1;
          end
        end
      end
      PH_COLLECT: begin
        if (is_byte) begin
          mem_we = 1'b1;
          tl_n   = short_to_q;
          if (bc_q == xmcr_pkg::IDX_CKS) begin
            bc_n = '0;
            chk  = 1'b1;
          end else begin
            bc_n = bc_q + AW'(1);
          end
        end else if (is_tick) begin
          tl_n = tl_dec;
          if (expired) begin
            ec_n  = ec_inc;
            bc_n  = '0;
            tl_n  = long_to_q;
            ph_n  = PH_RESPOND;
            rep_v = 1'b1;
          end
        end
      end
      PH_SINKWAIT: begin
        // Bytes are dropped and ticks leave the timeout alone here.
        if (sink_ready_i) begin
          tl_n     = long_to_q;
          ph_n     = PH_RESPOND;
          rep_v    = 1'b1;
          rep_byte = xmcr_pkg::SYM_ACK;
        end
      end
      PH_RESPOND: begin
        if (is_byte) begin
          if (rx_byte_i == xmcr_pkg::SYM_SOH) begin
            bc_n = AW'(1);
            tl_n = short_to_q;
            ph_n = PH_COLLECT;
          end else if (rx_byte_i == xmcr_pkg::SYM_EOT) begin
            ec_n     = '0;
            bc_n     = '0;
            ph_n     = PH_START;
            rep_v    = 1'b1;
            rep_byte = xmcr_pkg::SYM_ACK;
            rep_done = 1'b1;
          end
        end else if (is_tick) begin
          tl_n = tl_dec;
          if (expired) begin
            ec_n  = ec_inc;
            tl_n  = long_to_q;
            rep_v = 1'b1;
          end
        end
      end
      default: begin
        ph_n = PH_START;
      end
    endcase
  end

  // Frame buffer: written as bytes arrive, read one byte a cycle by the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      frame_mem[bc_q] <= rx_byte_i;
    end
    rd_data_q <= frame_mem[addr_q];
  end

  // Configuration, protocol state, sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_to_q    <= xmcr_pkg::SHORT_TO_RST;
      long_to_q     <= xmcr_pkg::LONG_TO_RST;
      err_lim_q     <= xmcr_pkg::ERR_LIM_RST;
      phase_q       <= PH_START;
      tl_q          <= '0;
      ec_q          <= '0;
      bc_q          <= '0;
      last_seq_q    <= '0;
      seq_q         <= '0;
      cmp_ok_q      <= 1'b0;
      cks_q         <= '0;
      sq_q          <= SQ_IDLE;
      pend_rep_q    <= 1'b0;
      rep_byte_q    <= xmcr_pkg::SYM_NAK;
      rep_done_q    <= 1'b0;
      addr_q        <= '0;
      lane_q        <= '0;
      rd_pend_q     <= 1'b0;
      sum_q         <= '0;
      word_q        <= '0;
      out_valid_q   <= 1'b0;
      reply_valid_q <= 1'b0;
      reply_byte_q  <= '0;
      data_valid_q  <= 1'b0;
      data_word_q   <= '0;
      data_last_q   <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          xmcr_pkg::REG_SHORT_TO: short_to_q <= cfg_data_i;
          xmcr_pkg::REG_LONG_TO:  long_to_q  <= cfg_data_i;
          xmcr_pkg::REG_ERR_LIM:  err_lim_q  <= cfg_data_i[EW-1:0];
          default: ;
        endcase
      end

      // Drop the held result once taken; a load below overrides this.
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (sq_q)
        SQ_IDLE: begin
          if (in_fire) begin
            phase_q    <= ph_n;
            ec_q       <= ec_n;
            tl_q       <= tl_n;
            bc_q       <= bc_n;
            pend_rep_q <= rep_v;
            rep_byte_q <= rep_byte;
            rep_done_q <= rep_done;
            if (mem_we && bc_q == xmcr_pkg::IDX_SEQ) begin
              seq_q <= rx_byte_i;
            end
            if (mem_we && bc_q == xmcr_pkg::IDX_CMP) begin
              cmp_ok_q <= (rx_byte_i == ~seq_q);
            end
            if (mem_we && bc_q == xmcr_pkg::IDX_CKS) begin
              cks_q <= rx_byte_i;
            end
            addr_q    <= xmcr_pkg::IDX_PAY0;
            sum_q     <= '0;
            rd_pend_q <= 1'b0;
            if (nak0) begin
              sq_q <= SQ_NAK0;
            end else if (rep_v) begin
              sq_q <= SQ_REPLY;
            end else if (chk) begin
              sq_q <= SQ_SUM;
            end
          end
        end
        SQ_NAK0: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            reply_valid_q <= 1'b1;
            reply_byte_q  <= xmcr_pkg::SYM_NAK;
            data_valid_q  <= 1'b0;
            data_word_q   <= '0;
            data_last_q   <= 1'b0;
            done_q        <= 1'b0;
            sq_q          <= pend_rep_q ? SQ_REPLY : SQ_IDLE;
          end
        end
        SQ_REPLY: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            reply_valid_q <= 1'b1;
            reply_byte_q  <= rep_byte_q;
            data_valid_q  <= 1'b0;
            data_word_q   <= '0;
            data_last_q   <= 1'b0;
            done_q        <= rep_done_q;
            sq_q          <= SQ_IDLE;
          end
        end
        SQ_SUM: begin
          // Issue one payload read a cycle; add the byte read the cycle before.
          if (rd_pend_q) begin
            sum_q <= sum_q + rd_data_q;
          end
          rd_pend_q <= 1'b1;
          if (addr_q == xmcr_pkg::IDX_PAYLAST) begin
            sq_q <= SQ_SUMEND;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        SQ_SUMEND: begin
          sum_q <= sum_q + rd_data_q;
          sq_q  <= SQ_VERDICT;
        end
        SQ_VERDICT: begin
          if (frame_ok && frame_new) begin
            last_seq_q <= seq_q;
            ec_q       <= '0;
            phase_q    <= PH_SINKWAIT;
            addr_q     <= xmcr_pkg::IDX_PAY0;
            lane_q     <= '0;
            rd_pend_q  <= 1'b0;
            sq_q       <= SQ_FETCH;
          end else if (slot_free) begin
            // Bad frame: NAK and count the error; repeated frame: ACK only.
            out_valid_q   <= 1'b1;
            reply_valid_q <= 1'b1;
            reply_byte_q  <= frame_ok ? xmcr_pkg::SYM_ACK : xmcr_pkg::SYM_NAK;
            data_valid_q  <= 1'b0;
            data_word_q   <= '0;
            data_last_q   <= 1'b0;
            done_q        <= 1'b0;
            tl_q          <= long_to_q;
            phase_q       <= PH_RESPOND;
            if (!frame_ok) begin
              ec_q <= (ec_q == xmcr_pkg::ERR_MAX) ? ec_q : ec_q + EW'(1);
            end
            sq_q <= SQ_IDLE;
          end
        end
        SQ_FETCH: begin
          // Shift bytes in from the top so the first byte ends up lowest.
          if (rd_pend_q) begin
            word_q <= {rd_data_q, word_q[63:8]};
          end
          rd_pend_q <= 1'b1;
          addr_q    <= addr_q + AW'(1);
          lane_q    <= lane_q + LW'(1);
          if (lane_q == LW'(xmcr_pkg::WORD_BYTES - 1)) begin
            sq_q <= SQ_FETCHEND;
          end
        end
        SQ_FETCHEND: begin
          word_q <= {rd_data_q, word_q[63:8]};
          sq_q   <= SQ_WORD;
        end
        SQ_WORD: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            reply_valid_q <= 1'b0;
            reply_byte_q  <= '0;
            data_valid_q  <= 1'b1;
            data_word_q   <= word_q;
            data_last_q   <= (addr_q == xmcr_pkg::IDX_CKS);
            done_q        <= 1'b0;
            rd_pend_q     <= 1'b0;
            lane_q        <= '0;
            sq_q          <= (addr_q == xmcr_pkg::IDX_CKS) ? SQ_IDLE : SQ_FETCH;
          end
        end
        default: begin
          sq_q <= SQ_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reply_valid_o   = reply_valid_q;
  assign reply_byte_o    = reply_byte_q;
  assign data_valid_o    = data_valid_q;
  assign data_word_o     = data_word_q;
  assign data_last_o     = data_last_q;
  assign transfer_done_o = done_q;

endmodule

### tb/xmcr_tb_pkg.sv
// Tracker for the XMODEM receiver testbench: predicted protocol state and awaited result items.
`timescale 1ns / 1ps
package xmcr_tb_pkg;
  import xmcr_pkg::*;

  localparam logic [1:0]  KIND_POLL     = 2'd2;
  localparam logic [1:0]  KIND_SPARE    = 2'd3;
  localparam int unsigned PAYLOAD_WORDS = (FRAME_BYTES - 4) / WORD_BYTES;

  typedef enum logic [2:0] {
    LINK_START,
    LINK_CONNECT,
    LINK_COLLECT,
    LINK_SINK_WAIT,
    LINK_RESPOND
  } link_phase_e;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        data_valid;
    logic [63:0] data_word;
    logic        data_last;
    logic        transfer_done;
  } link_result_t;

  class xmodem_rx_tracker;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [ERR_W-1:0]  err_limit;
    link_phase_e       phase;
    logic [7:0]        frame [FRAME_BYTES];
    int unsigned       fill;
    logic [TICK_W-1:0] ticks_left;
    logic [ERR_W-1:0]  err_count;
    logic [7:0]        last_seq;
    link_result_t      outputs_due [$];
    int unsigned       fail_count;
    int unsigned       matched;

    function new();
      short_ticks = SHORT_TO_RST;
      long_ticks  = LONG_TO_RST;
      err_limit   = ERR_LIM_RST;
      phase       = LINK_START;
      fill        = 0;
      ticks_left  = '0;
      err_count   = '0;
      last_seq    = '0;
      fail_count  = 0;
      matched     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_SHORT_TO: begin
          short_ticks = value;
        end
        REG_LONG_TO: begin
          long_ticks = value;
        end
        REG_ERR_LIM: begin
          err_limit = value[ERR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned due_count();
      return outputs_due.size();
    endfunction

    function void push_reply(logic [7:0] code, logic done);
      link_result_t r;
      r = '0;
      r.reply_valid   = 1'b1;
      r.reply_byte    = code;
      r.transfer_done = done;
      outputs_due.push_back(r);
    endfunction

    function void bump_errors();
      if (err_count != ERR_MAX) err_count++;
    endfunction

    function bit tick_runs_out();
      if (ticks_left != '0) ticks_left--;
      return ticks_left == '0;
    endfunction

    function void open_frame();
      frame[0]   = SYM_SOH;
      fill       = 1;
      ticks_left = short_ticks;
      phase      = LINK_COLLECT;
    endfunction

    // Timeout while collecting, or a frame that fails its checks.
    function void fail_back();
      bump_errors();
      fill       = 0;
      ticks_left = long_ticks;
      phase      = LINK_RESPOND;
      push_reply(SYM_NAK, 1'b0);
    endfunction

    function void judge_frame();
      logic [7:0]   sum;
      link_result_t r;
      int unsigned  i;
      int unsigned  w;
      int unsigned  k;
      sum  = '0;
      fill = 0;
      for (i = IDX_PAY0; i <= IDX_PAYLAST; i++) sum += frame[i];
      if (frame[0] != SYM_SOH || frame[IDX_CMP] != ~frame[IDX_SEQ] || sum != frame[IDX_CKS]) begin
        fail_back();
      end else if (frame[IDX_SEQ] == last_seq) begin
        ticks_left = long_ticks;
        phase      = LINK_RESPOND;
        push_reply(SYM_ACK, 1'b0);
      end else begin
        for (w = 0; w < PAYLOAD_WORDS; w++) begin
          r = '0;
          r.data_valid = 1'b1;
          r.data_last  = (w == PAYLOAD_WORDS - 1);
          for (k = 0; k < WORD_BYTES; k++) r.data_word[8*k +: 8] = frame[IDX_PAY0 + w*WORD_BYTES + k];
          outputs_due.push_back(r);
        end
        last_seq  = frame[IDX_SEQ];
        err_count = '0;
        phase     = LINK_SINK_WAIT;
      end
    endfunction

    function void take_item(logic [1:0] kind, logic [7:0] b, logic ready);
      logic is_byte;
      logic is_tick;
      is_byte = (kind == KIND_BYTE);
      is_tick = (kind == KIND_TICK);
      if (phase == LINK_RESPOND && err_count >= err_limit) begin
        err_count = '0;
        phase     = LINK_START;
      end
      if (phase == LINK_START) begin
        push_reply(SYM_NAK, 1'b0);
        ticks_left = short_ticks;
        phase      = LINK_CONNECT;
      end
      case (phase)
        LINK_CONNECT: begin
          if (is_byte && b == SYM_SOH) begin
            open_frame();
          end else if (is_tick && tick_runs_out()) begin
            ticks_left = short_ticks;
            push_reply(SYM_NAK, 1'b0);
          end
        end
        LINK_COLLECT: begin
          if (is_byte) begin
            frame[fill] = b;
            fill++;
            ticks_left = short_ticks;
            if (fill >= FRAME_BYTES) judge_frame();
          end else if (is_tick && tick_runs_out()) begin
            fail_back();
          end
        end
        LINK_SINK_WAIT: begin
          if (ready) begin
            ticks_left = long_ticks;
            phase      = LINK_RESPOND;
            push_reply(SYM_ACK, 1'b0);
          end
        end
        LINK_RESPOND: begin
          if (is_byte) begin
            if (b == SYM_SOH) begin
              open_frame();
            end else if (b == SYM_EOT) begin
              err_count = '0;
              fill      = 0;
              phase     = LINK_START;
              push_reply(SYM_ACK, 1'b1);
            end
          end else if (is_tick && tick_runs_out()) begin
            bump_errors();
            ticks_left = long_ticks;
            push_reply(SYM_NAK, 1'b0);
          end
        end
        default: begin
          phase = LINK_START;
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      fail_count++;
    endtask

    task match_output(link_result_t got);
      link_result_t want;
      if (outputs_due.size() == 0) begin
        report($sformatf("unexpected item reply %0b/%0d data %0b/%h last %0b done %0b",
                         got.reply_valid, got.reply_byte, got.data_valid, got.data_word,
                         got.data_last, got.transfer_done));
        return;
      end
      want = outputs_due.pop_front();
      if (got.reply_valid !== want.reply_valid || got.reply_byte !== want.reply_byte ||
          got.data_valid !== want.data_valid || got.data_word !== want.data_word ||
          got.data_last !== want.data_last || got.transfer_done !== want.transfer_done) begin
        report($sformatf("got %0b/%0d %0b/%h %0b %0b, want %0b/%0d %0b/%h %0b %0b",
                         got.reply_valid, got.reply_byte, got.data_valid, got.data_word,
                         got.data_last, got.transfer_done, want.reply_valid, want.reply_byte,
                         want.data_valid, want.data_word, want.data_last, want.transfer_done));
      end else begin
        matched++;
      end
    endtask
  endclass

endpackage

### tb/tb_top.sv
// Testbench top: drives byte, tick and poll items into the XMODEM receiver and checks results.
`timescale 1ns / 1ps
module tb_top;
  import xmcr_pkg::*;
  import xmcr_tb_pkg::*;

  localparam int unsigned RESET_CYCLES = 9;
  // Drain time must cover a frame check sweep plus sixteen-word delivery; keep a margin.
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned ITEMS_TARGET = 165;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  rx_byte_i;
  logic        sink_ready_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        reply_valid_o;
  logic [7:0]  reply_byte_o;
  logic        data_valid_o;
  logic [63:0] data_word_o;
  logic        data_last_o;
  logic        transfer_done_o;

  xmodem_rx_tracker tracker;
  int unsigned      items_sent;
  bit               send_calm;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  xmodem_checksum_receiver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .rx_byte_i      (rx_byte_i),
    .sink_ready_i   (sink_ready_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .data_valid_o   (data_valid_o),
    .data_word_o    (data_word_o),
    .data_last_o    (data_last_o),
    .transfer_done_o(transfer_done_o)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until accepted. Called in the step of the previous
  // acceptance, so either drop valid for a gap or replace the payload right away.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b, input logic ready);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    if (!send_calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    rx_byte_i    <= b;
    sink_ready_i <= ready;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_item(kind, b, ready);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid, let every awaited item drain, then give the sequencer time to settle
  // in case the last item started work that produces nothing.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.due_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] short_v, input logic [15:0] long_v,
                              input logic [15:0] lim_v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SHORT_TO;
    cfg_data_i <= short_v;
    @(posedge clk_i);
    tracker.set_reg(REG_SHORT_TO, short_v);
    cfg_idx_i  <= REG_LONG_TO;
    cfg_data_i <= long_v;
    @(posedge clk_i);
    tracker.set_reg(REG_LONG_TO, long_v);
    cfg_idx_i  <= REG_ERR_LIM;
    cfg_data_i <= lim_v;
    @(posedge clk_i);
    tracker.set_reg(REG_ERR_LIM, lim_v);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: check every accepted item, stall at random, and once hold off for a
  // long stretch in the middle of a payload so the block backs up and stalls its input.
  initial begin : result_side
    int unsigned  stall_left;
    int unsigned  words_taken;
    bit           calm;
    bit           held;
    link_result_t got;
    stall_left  = 0;
    words_taken = 0;
    calm        = 1'b0;
    held        = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        got = {reply_valid_o, reply_byte_o, data_valid_o, data_word_o, data_last_o,
               transfer_done_o};
        tracker.match_output(got);
        if (data_valid_o) words_taken++;
      end
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (!held && words_taken == 3) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Hard stop: count cycles and give up well past the slowest correct run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[xmodem_checksum_receiver_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  body [FRAME_BYTES];
    logic [7:0]  sum;
    int unsigned i;
    int unsigned n;
    int unsigned pick;
    tracker    = new();
    items_sent = 0;
    send_calm  = 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_SHORT_TO;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_POLL;
    rx_byte_i    <= '0;
    sink_ready_i <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values: first event NAKs and opens the connection,
    // then kind 3, extreme bytes, EOT and a tick that does not expire are all quiet.
    send_item(KIND_POLL, 8'h00, 1'b0);
    send_item(KIND_SPARE, 8'hFF, 1'b1);
    send_item(KIND_BYTE, 8'hFF, 1'b1);
    send_item(KIND_BYTE, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'hFF, 1'b0);
    send_item(KIND_BYTE, SYM_EOT, 1'b1);

    // Zero timeouts expire on the next tick; zero error limit restarts on any respond event.
    program_regs(16'd0, 16'd0, 16'd0);
    send_item(KIND_BYTE, SYM_SOH, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_POLL, 8'h00, 1'b1);
    send_item(KIND_TICK, 8'hFF, 1'b1);

    // Shortest timeouts, highest error limit: collect timeout, ignored byte in respond,
    // respond timeout, EOT ending the transfer, then a fresh start and connect timeout.
    program_regs(16'd1, 16'd2, 16'd15);
    send_item(KIND_BYTE, SYM_SOH, 1'b1);
    send_item(KIND_BYTE, 8'hAA, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_BYTE, 8'h55, 1'b1);
    send_item(KIND_TICK, 8'h00, 1'b1);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_BYTE, SYM_EOT, 1'b0);
    send_item(KIND_SPARE, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_BYTE, SYM_SOH, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);

    // Random small settings, then one well-formed frame with a new sequence number and
    // random payload, with a stray poll or spare item now and then between its bytes.
    program_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 15)));
    body[0]       = SYM_SOH;
    body[IDX_SEQ] = tracker.last_seq + 8'd1;
    body[IDX_CMP] = ~body[IDX_SEQ];
    sum = '0;
    for (i = IDX_PAY0; i <= IDX_PAYLAST; i++) begin
      body[i] = 8'($urandom_range(0, 255));
      sum += body[i];
    end
    body[IDX_CKS] = sum;
    // Lead with a poll: restarts the connection when the error limit is already met.
    send_item(KIND_POLL, 8'($urandom), 1'($urandom_range(0, 1)));
    for (i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_item(2'($urandom_range(2, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
      send_item(KIND_BYTE, body[i], 1'($urandom_range(0, 1)));
    end

    // Keep offering items while the payload drains: EOT, ticks and noise with SOH
    // thrown in now and then, up to the item budget.
    while (items_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_item(KIND_BYTE, SYM_EOT, 1'($urandom_range(0, 1)));
      end else if (pick < 50) begin
        send_ticks($urandom_range(1, 4));
      end else begin
        n = $urandom_range(3, 6);
        repeat (n) begin
          send_item(2'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? SYM_SOH : 8'($urandom),
                    1'($urandom_range(0, 1)));
        end
      end
    end

    wait_idle();
    if (tracker.fail_count == 0) begin
      $display("[xmodem_checksum_receiver_top] OK");
    end else begin
      $display("[xmodem_checksum_receiver_top] ERROR");
    end
    $finish;
  end

endmodule
